/* sv/lzss_pkg.sv */
`timescale 1ns / 1ps

package lzss_pkg;

   // Physical window: address width and depth.
   localparam int WIN_BITS  = 12;
   localparam int WIN_DEPTH = 1 << WIN_BITS;
   // Width that holds an effective index_bits value (up to WIN_BITS).
   localparam int IB_W      = $clog2(WIN_BITS + 1);
   // Copy length: coded length up to 31 plus min_match up to 15.
   localparam int LEN_W     = 6;
   localparam int CNT_W     = 21;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 21;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BITS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_BITS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_MATCH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_BACK  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_MODE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_BYTE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_OUTPUT  = 3'd6;

   // Window fill modes.
   localparam logic [1:0] INIT_FILL       = 2'd0;
   localparam logic [1:0] INIT_INTERLEAVE = 2'd1;
   localparam logic [1:0] INIT_ASCENDING  = 2'd2;

   typedef struct packed {
      logic [3:0]       index_bits;
      logic [2:0]       length_bits;
      logic [3:0]       min_match;
      logic [3:0]       start_back;
      logic [1:0]       init_mode;
      logic [7:0]       fill_byte;
      logic [CNT_W-1:0] max_output;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      index_bits:  4'd12,
      length_bits: 3'd4,
      min_match:   4'd2,
      start_back:  4'd2,
      init_mode:   INIT_FILL,
      fill_byte:   8'd0,
      max_output:  CNT_W'(1 << 20)
   };

   typedef struct packed {
      logic                rd_en;
      logic [WIN_BITS-1:0] rd_addr;
      logic                wr_en;
      logic [WIN_BITS-1:0] wr_addr;
      logic [7:0]          wr_data;
   } win_req_type;

   typedef struct packed {
      logic sweeping;
      logic halted;
   } dec_status_type;

   function automatic logic [IB_W-1:0] eff_index_bits(input logic [3:0] v);
      logic [IB_W-1:0] r;
      if (int'(v) < 8) begin
         r = IB_W'(8);
      end else if (int'(v) > WIN_BITS) begin
         r = IB_W'(WIN_BITS);
      end else begin
         r = IB_W'(v);
      end
      return r;
   endfunction

   function automatic logic [2:0] eff_length_bits(input logic [2:0] v);
      logic [2:0] r;
      if (v < 3'd2) begin
         r = 3'd2;
      end else if (v > 3'd5) begin
         r = 3'd5;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [WIN_BITS-1:0] win_mask(input logic [IB_W-1:0] eib);
      logic [WIN_BITS-1:0] m;
      for (int i = 0; i < WIN_BITS; i++) begin
         m[i] = (i < int'(eib));
      end
      return m;
   endfunction

endpackage

/* sv/lzss_if.sv */
`timescale 1ns / 1ps

interface lzss_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       block_start;

   modport source (output valid, output in_byte, output block_start, input ready);
   modport sink   (input valid, input in_byte, input block_start, output ready);
endinterface

interface lzss_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

/* sv/lzss_window.sv */
`timescale 1ns / 1ps

module lzss_window import lzss_pkg::*; (
   input  logic        clock,
   input  win_req_type win_req,
   output logic [7:0]  rd_data
);

   logic [7:0] mem [WIN_DEPTH];
   logic [7:0] q_ff;
   logic       fwd_ff;
   logic [7:0] fwd_data_ff;

   // Read returns the old entry; forward a write to the same entry in that cycle.
   always_ff @(posedge clock) begin
      if (win_req.wr_en) begin
         mem[win_req.wr_addr] <= win_req.wr_data;
      end
      if (win_req.rd_en) begin
         q_ff        <= mem[win_req.rd_addr];
         fwd_ff      <= win_req.wr_en && (win_req.wr_addr == win_req.rd_addr);
         fwd_data_ff <= win_req.wr_data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : q_ff;

endmodule

/* sv/lzss_decoder.sv */
`timescale 1ns / 1ps

module lzss_decoder import lzss_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [7:0]     in_byte,
   input  logic           in_block_start,
   output logic           out_valid,
   input  logic           out_ready,
   output logic [7:0]     out_byte,
   output logic           out_last,
   output win_req_type    win_req,
   input  logic [7:0]     win_rd_data,
   output dec_status_type status
);

   typedef enum logic [1:0] {S_SWEEP, S_IDLE, S_LIT, S_COPY} state_type;
   typedef enum logic [1:0] {PH_FLAG, PH_ITEM, PH_TOKEN} phase_type;

   state_type           state_ff, state_in;
   phase_type           phase_ff, phase_in;
   logic [WIN_BITS-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic [7:0]          sweep_byte_ff, sweep_byte_in;
   logic                sweep_has_ff, sweep_has_in;
   logic [WIN_BITS-1:0] wp_ff, wp_in;
   logic [7:0]          flag_bits_ff, flag_bits_in;
   logic [3:0]          flags_left_ff, flags_left_in;
   logic [7:0]          offset_low_ff, offset_low_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                halted_ff, halted_in;
   logic [7:0]          lit_ff, lit_in;
   logic [WIN_BITS-1:0] off_ff, off_in;
   logic [LEN_W-1:0]    k_ff, k_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic                pend_ff, pend_in;
   logic                out_valid_ff, out_valid_in;
   logic [7:0]          out_byte_ff, out_byte_in;
   logic                out_last_ff, out_last_in;

   logic [IB_W-1:0]       eib;
   logic [2:0]            elb;
   logic [WIN_BITS-1:0]   mask;
   logic [WIN_BITS-1:0]   wp_init;
   logic [WIN_BITS+7:0]   off_wide;
   logic [7:0]            len_mask;
   logic [LEN_W-1:0]      rd_idx;
   logic                  limit_hit;
   logic                  next_full;
   logic                  slot_free;
   logic                  emit_last;
   logic [7:0]            sweep_data;
   logic [3:0]            left_dec;

   assign eib       = eff_index_bits(cfg.index_bits);
   assign elb       = eff_length_bits(cfg.length_bits);
   assign mask      = win_mask(eib);
   assign wp_init   = ((WIN_BITS)'(0) - ((WIN_BITS)'(1) << elb)
                       - (WIN_BITS)'(cfg.start_back)) & mask;
   assign off_wide  = (((WIN_BITS + 8)'(in_byte >> elb)) << 8) | (WIN_BITS + 8)'(offset_low_ff);
   assign len_mask  = 8'((9'd1 << elb) - 9'd1);
   assign rd_idx    = pend_ff ? k_ff + LEN_W'(1) : k_ff;
   assign limit_hit = count_ff >= cfg.max_output;
   assign next_full = ({1'b0, count_ff} + (CNT_W + 1)'(1)) >= {1'b0, cfg.max_output};
   assign slot_free = !out_valid_ff || out_ready;
   assign emit_last = (k_ff == len_ff) || next_full;
   assign left_dec  = (flags_left_ff != 4'd0) ? flags_left_ff - 4'd1 : 4'd0;

   always_comb begin
      unique case (cfg.init_mode)
         INIT_INTERLEAVE: sweep_data = (sweep_cnt_ff[2:0] == 3'd6) ? 8'(sweep_cnt_ff >> 3) : 8'd0;
         INIT_ASCENDING:  sweep_data = 8'(sweep_cnt_ff);
         default:         sweep_data = cfg.fill_byte;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      sweep_byte_in = sweep_byte_ff;
      sweep_has_in  = sweep_has_ff;
      wp_in         = wp_ff;
      flag_bits_in  = flag_bits_ff;
      flags_left_in = flags_left_ff;
      offset_low_in = offset_low_ff;
      count_in      = count_ff;
      halted_in     = halted_ff;
      lit_in        = lit_ff;
      off_in        = off_ff;
      k_in          = k_ff;
      len_in        = len_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !out_ready;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      win_req         = '0;
      win_req.rd_addr = (off_ff + WIN_BITS'(rd_idx)) & mask;
      win_req.wr_addr = wp_ff & mask;

      unique case (state_ff)
         S_SWEEP: begin
            win_req.wr_en   = 1'b1;
            win_req.wr_addr = sweep_cnt_ff;
            win_req.wr_data = sweep_data;
            sweep_cnt_in    = sweep_cnt_ff + WIN_BITS'(1);
            if (&sweep_cnt_ff) begin
               state_in = S_IDLE;
               wp_in    = wp_init;
               // the request that opened the block is its first flag byte
               if (sweep_has_ff) begin
                  flag_bits_in  = sweep_byte_ff;
                  flags_left_in = 4'd8;
                  phase_in      = PH_ITEM;
               end
            end
         end
         S_IDLE: begin
            if (in_valid) begin
               if (in_block_start) begin
                  state_in      = S_SWEEP;
                  sweep_cnt_in  = '0;
                  sweep_has_in  = 1'b1;
                  sweep_byte_in = in_byte;
                  flag_bits_in  = 8'd0;
                  flags_left_in = 4'd0;
                  phase_in      = PH_FLAG;
                  offset_low_in = 8'd0;
                  count_in      = '0;
                  halted_in     = 1'b0;
               end else if (!halted_ff) begin
                  unique case (phase_ff)
                     PH_FLAG: begin
                        flag_bits_in  = in_byte;
                        flags_left_in = 4'd8;
                        phase_in      = PH_ITEM;
                     end
                     PH_ITEM: begin
                        if (flag_bits_ff[0]) begin
                           flag_bits_in  = flag_bits_ff >> 1;
                           flags_left_in = left_dec;
                           phase_in      = (left_dec != 4'd0) ? PH_ITEM : PH_FLAG;
                           lit_in        = in_byte;
                           state_in      = S_LIT;
                        end else begin
                           offset_low_in = in_byte;
                           phase_in      = PH_TOKEN;
                        end
                     end
                     PH_TOKEN: begin
                        flag_bits_in  = flag_bits_ff >> 1;
                        flags_left_in = left_dec;
                        phase_in      = (left_dec != 4'd0) ? PH_ITEM : PH_FLAG;
                        off_in        = off_wide[WIN_BITS-1:0] & mask;
                        len_in        = LEN_W'(in_byte & len_mask) + LEN_W'(cfg.min_match);
                        k_in          = '0;
                        pend_in       = 1'b0;
                        state_in      = S_COPY;
                     end
                     default: phase_in = PH_FLAG;
                  endcase
               end
            end
         end
         S_LIT: begin
            if (limit_hit) begin
               halted_in = 1'b1;
               state_in  = S_IDLE;
            end else if (slot_free) begin
               out_valid_in    = 1'b1;
               out_byte_in     = lit_ff;
               out_last_in     = 1'b1;
               win_req.wr_en   = 1'b1;
               win_req.wr_data = lit_ff;
               wp_in           = (wp_ff + WIN_BITS'(1)) & mask;
               count_in        = count_ff + CNT_W'(1);
               state_in        = S_IDLE;
            end
         end
         S_COPY: begin
            if (limit_hit) begin
               // drop the pending read and stop the block
               halted_in = 1'b1;
               pend_in   = 1'b0;
               state_in  = S_IDLE;
            end else if (pend_ff) begin
               if (slot_free) begin
                  out_valid_in    = 1'b1;
                  out_byte_in     = win_rd_data;
                  out_last_in     = emit_last;
                  win_req.wr_en   = 1'b1;
                  win_req.wr_data = win_rd_data;
                  wp_in           = (wp_ff + WIN_BITS'(1)) & mask;
                  count_in        = count_ff + CNT_W'(1);
                  if (emit_last) begin
                     halted_in = (k_ff != len_ff);
                     pend_in   = 1'b0;
                     state_in  = S_IDLE;
                  end else begin
                     win_req.rd_en = 1'b1;
                     k_in          = k_ff + LEN_W'(1);
                  end
               end
            end else begin
               win_req.rd_en = 1'b1;
               pend_in       = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         phase_ff      <= PH_FLAG;
         sweep_cnt_ff  <= '0;
         sweep_has_ff  <= 1'b0;
         flag_bits_ff  <= 8'd0;
         flags_left_ff <= 4'd0;
         offset_low_ff <= 8'd0;
         count_ff      <= '0;
         halted_ff     <= 1'b0;
         pend_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         sweep_has_ff  <= sweep_has_in;
         flag_bits_ff  <= flag_bits_in;
         flags_left_ff <= flags_left_in;
         offset_low_ff <= offset_low_in;
         count_ff      <= count_in;
         halted_ff     <= halted_in;
         pend_ff       <= pend_in;
         out_valid_ff  <= out_valid_in;
      end
      sweep_byte_ff <= sweep_byte_in;
      wp_ff         <= wp_in;
      lit_ff        <= lit_in;
      off_ff        <= off_in;
      k_ff          <= k_in;
      len_ff        <= len_in;
      out_byte_ff   <= out_byte_in;
      out_last_ff   <= out_last_in;
   end

   assign in_ready        = (state_ff == S_IDLE);
   assign out_valid       = out_valid_ff;
   assign out_byte        = out_byte_ff;
   assign out_last        = out_last_ff;
   assign status.sweeping = (state_ff == S_SWEEP);
   assign status.halted   = halted_ff;

endmodule

/* sv/lzss_decompressor.sv */
`timescale 1ns / 1ps

// LZSS decompressor: takes one compressed byte per request and returns the decoded
// bytes as a stream of responses, out_last marking the final byte caused by a request.
// A flag byte and the first byte of a token give no response; a literal gives one byte;
// the second byte of a token that copies L bytes gives those bytes from the window, one
// byte per cycle while the response side takes them. The window is one 2^WIN_BITS x 8
// synchronous memory with one read and one write port, and that read port sets the copy
// rate; a copy read of the entry that is being written in the same cycle is served by
// forwarding. A request with block_start set, and reset itself, start a fill pass over
// the whole window, during which no request is taken; configuration writes are taken at
// any time. Output bytes wait in a register, so the next request is taken while the last
// byte is still waiting on the response side.

module lzss_decompressor import lzss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lzss_req_if.sink              req,
   lzss_rsp_if.source            rsp,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type        cfg_ff;
   win_req_type    win_req;
   logic [7:0]     win_rd_data;
   dec_status_type status;

   // Configuration registers; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_INDEX_BITS:  cfg_ff.index_bits  <= csr_wdata[3:0];
            CSR_LENGTH_BITS: cfg_ff.length_bits <= csr_wdata[2:0];
            CSR_MIN_MATCH:   cfg_ff.min_match   <= csr_wdata[3:0];
            CSR_START_BACK:  cfg_ff.start_back  <= csr_wdata[3:0];
            CSR_INIT_MODE:   cfg_ff.init_mode   <= csr_wdata[1:0];
            CSR_FILL_BYTE:   cfg_ff.fill_byte   <= csr_wdata[7:0];
            CSR_MAX_OUTPUT:  cfg_ff.max_output  <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Decoder: flag/token sequencing, window fill and the copy engine.
   lzss_decoder u_decoder (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .in_valid       (req.valid),
      .in_ready       (req.ready),
      .in_byte        (req.in_byte),
      .in_block_start (req.block_start),
      .out_valid      (rsp.valid),
      .out_ready      (rsp.ready),
      .out_byte       (rsp.out_byte),
      .out_last       (rsp.out_last),
      .win_req        (win_req),
      .win_rd_data    (win_rd_data),
      .status         (status)
   );

   // Sliding window memory.
   lzss_window u_window (
      .clock   (clock),
      .win_req (win_req),
      .rd_data (win_rd_data)
   );

   // No window read while the fill pass owns the memory.
   assert property (@(posedge clock) disable iff (reset)
      status.sweeping |-> !win_req.rd_en)
      else $error("window read during fill pass");

   // Every window write outside the fill pass loads a response byte.
   assert property (@(posedge clock) disable iff (reset)
      (win_req.wr_en && !status.sweeping) |=> rsp.valid)
      else $error("window write without a response byte");

   // Once halted, the window is left alone until the next block.
   assert property (@(posedge clock) disable iff (reset)
      status.halted |-> !win_req.wr_en)
      else $error("window written while halted");

   // A request is never taken during the fill pass.
   assert property (@(posedge clock) disable iff (reset)
      status.sweeping |-> !req.ready)
      else $error("request taken during fill pass");

endmodule

/* test/lzss_tb_pkg.sv */
`timescale 1ns / 1ps

package lzss_tb_pkg;
   import lzss_pkg::*;

   typedef enum logic [1:0] {
      EXPECT_FLAGS,
      EXPECT_ITEM,
      EXPECT_TOKEN_HI
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_byte_type;

   // Bit-accurate decoder of the compressed stream plus the queue of bytes it predicts.
   class lzss_decode_checker;
      cfg_type      regs;
      logic [7:0]   window [WIN_DEPTH];
      int unsigned  wr_pos;
      logic [7:0]   flag_bits;
      int unsigned  flags_left;
      parse_phase_type phase;
      logic [7:0]   offset_low;
      logic [CNT_W-1:0] out_count;
      bit           halted;
      out_byte_type pending_bytes[$];
      int unsigned  mismatches;

      function new();
         regs = CFG_RESET;
         mismatches = 0;
         restart_block();
      endfunction

      function int unsigned index_width();
         int unsigned w;
         w = regs.index_bits;
         if (w < 8) w = 8;
         if (w > WIN_BITS) w = WIN_BITS;
         return w;
      endfunction

      function int unsigned length_width();
         int unsigned w;
         w = regs.length_bits;
         if (w < 2) w = 2;
         if (w > 5) w = 5;
         return w;
      endfunction

      // Refill the whole physical window, not just the active part.
      function void restart_block();
         int unsigned n;
         n = 1 << index_width();
         for (int i = 0; i < WIN_DEPTH; i++) begin
            case (regs.init_mode)
               INIT_INTERLEAVE: window[i] = ((i & 7) == 6) ? 8'(i >> 3) : 8'h00;
               INIT_ASCENDING:  window[i] = 8'(i);
               default:         window[i] = regs.fill_byte;
            endcase
         end
         wr_pos = (n - (1 << length_width()) - regs.start_back) & (n - 1);
         flag_bits = 8'h00;
         flags_left = 0;
         phase = EXPECT_FLAGS;
         offset_low = 8'h00;
         out_count = '0;
         halted = 1'b0;
      endfunction

      function bit put_byte(logic [7:0] c);
         int unsigned mask;
         mask = (1 << index_width()) - 1;
         if (out_count >= regs.max_output) begin
            halted = 1'b1;
            return 1'b0;
         end
         pending_bytes.push_back('{data: c, last: 1'b0});
         window[wr_pos & mask] = c;
         wr_pos = (wr_pos + 1) & mask;
         out_count = out_count + 1'b1;
         return 1'b1;
      endfunction

      function void next_flag();
         flag_bits = flag_bits >> 1;
         if (flags_left > 0) flags_left--;
         phase = (flags_left != 0) ? EXPECT_ITEM : EXPECT_FLAGS;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_INDEX_BITS:  regs.index_bits  = data[3:0];
            CSR_LENGTH_BITS: regs.length_bits = data[2:0];
            CSR_MIN_MATCH:   regs.min_match   = data[3:0];
            CSR_START_BACK:  regs.start_back  = data[3:0];
            CSR_INIT_MODE:   regs.init_mode   = data[1:0];
            CSR_FILL_BYTE:   regs.fill_byte   = data[7:0];
            CSR_MAX_OUTPUT:  regs.max_output  = data[CNT_W-1:0];
            default: ;
         endcase
      endfunction

      // Decode one accepted request and queue the bytes it produces.
      function void decode_request(logic [7:0] b, logic first);
         int unsigned queued, lb, mask, off, len;
         if (first) restart_block();
         if (halted) return;
         queued = pending_bytes.size();
         case (phase)
            EXPECT_FLAGS: begin
               flag_bits = b;
               flags_left = 8;
               phase = EXPECT_ITEM;
            end
            EXPECT_ITEM: begin
               if (flag_bits[0]) begin
                  next_flag();
                  void'(put_byte(b));
               end else begin
                  offset_low = b;
                  phase = EXPECT_TOKEN_HI;
               end
            end
            default: begin
               lb = length_width();
               mask = (1 << index_width()) - 1;
               off = int'(offset_low) | ((int'(b) >> lb) << 8);
               len = (int'(b) & ((1 << lb) - 1)) + regs.min_match;
               next_flag();
               for (int k = 0; k <= len; k++) begin
                  if (!put_byte(window[(off + k) & mask])) break;
               end
            end
         endcase
         if (pending_bytes.size() > queued) pending_bytes[pending_bytes.size() - 1].last = 1'b1;
      endfunction

      function void check_output_byte(logic [7:0] data, logic last);
         out_byte_type want;
         if (pending_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected output byte %02h last %0b", data, last);
            return;
         end
         want = pending_bytes.pop_front();
         if (data !== want.data || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("output mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                        want.data, want.last, data, last);
         end
      endfunction
   endclass

endpackage

/* test/tb_lzss_decompressor.sv */
`timescale 1ns / 1ps

module tb_lzss_decompressor;
   import lzss_pkg::*;
   import lzss_tb_pkg::*;

   // One compressed byte as it goes out on the request channel.
   typedef struct packed {
      logic [7:0] data;
      logic       first;
   } request_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lzss_req_if req_ch();
   lzss_rsp_if rsp_ch();

   lzss_decode_checker decoder = new();
   request_type stream[$];
   int unsigned sent_count = 0;
   bit          hold_req = 1'b0;

   lzss_decompressor DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Check every response accepted at a rising edge against the oldest predicted byte.
   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready)
         decoder.check_output_byte(rsp_ch.out_byte, rsp_ch.out_last);
   end

   // Response side: pick a new stall pattern when one runs out. On request from the
   // stimulus, hold ready low for a long stretch so the block backs up into its input.
   initial begin : response_sink
      int unsigned mode, left;
      rsp_ch.ready = 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ch.ready = 1'b0;
            repeat (400) @(negedge clock);
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(16, 96);
            end
            left--;
            case (mode)
               0:       rsp_ch.ready = 1'b1;
               1:       rsp_ch.ready = ($urandom_range(0, 3) != 0);
               2:       rsp_ch.ready = (left % 3 == 0);
               default: rsp_ch.ready = ($urandom_range(0, 1) == 1);
            endcase
         end
      end
   end

   // Drive one request at the falling edge and hold it until the block takes it.
   task automatic send_request(input logic [7:0] data, input logic first);
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.in_byte = data;
      req_ch.block_start = first;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      decoder.decode_request(data, first);
      sent_count++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      decoder.write_reg(idx, data);
   endtask

   task automatic configure(input cfg_type c);
      write_csr(CSR_INDEX_BITS,  CSR_DATA_W'(c.index_bits));
      write_csr(CSR_LENGTH_BITS, CSR_DATA_W'(c.length_bits));
      write_csr(CSR_MIN_MATCH,   CSR_DATA_W'(c.min_match));
      write_csr(CSR_START_BACK,  CSR_DATA_W'(c.start_back));
      write_csr(CSR_INIT_MODE,   CSR_DATA_W'(c.init_mode));
      write_csr(CSR_FILL_BYTE,   CSR_DATA_W'(c.fill_byte));
      write_csr(CSR_MAX_OUTPUT,  CSR_DATA_W'(c.max_output));
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Drop valid, wait for every predicted byte, then let a full window fill pass go by,
   // since a trailing block start or flag byte leaves the block busy with no response.
   task automatic quiesce();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (decoder.pending_bytes.size() != 0) @(posedge clock);
      repeat (WIN_DEPTH + 100) @(posedge clock);
   endtask

   // Append one flag byte and the literals and tokens it announces. A partial group is
   // cut short at a random byte, often in the middle of a token.
   function automatic void add_group(input logic first, input bit partial);
      logic [7:0]  flags;
      int unsigned limit, n;
      flags = 8'($urandom);
      limit = partial ? $urandom_range(1, 12) : 16;
      n = 0;
      stream.push_back('{flags, first});
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < (flags[i] ? 1 : 2); j++) begin
            if (n < limit) stream.push_back('{8'($urandom), 1'b0});
            n++;
         end
      end
   endfunction

   // Mostly well-formed blocks with random content, some noise bytes and cut-off groups.
   // Every fourth phase carries on the block of the previous phase under the new setting.
   function automatic void build_phase(input int unsigned phase_no);
      logic first;
      first = (phase_no % 4 != 3);
      while (stream.size() < 40) begin
         add_group(first, 1'b0);
         repeat ($urandom_range(0, 2)) add_group(1'b0, 1'b0);
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) stream.push_back('{8'($urandom), 1'b0});
         if ($urandom_range(0, 2) == 0) add_group(1'b0, 1'b1);
         first = 1'b1;
      end
   endfunction

   // Send the stream in bursts of random length, with random gaps or long gap-free runs.
   task automatic play_stream(input bit with_hold);
      int unsigned burst_left, gap;
      burst_left = 0;
      for (int k = 0; k < stream.size(); k++) begin
         if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
               burst_left = 64;
               gap = 0;
            end else begin
               burst_left = $urandom_range(1, 10);
               gap = $urandom_range(1, 6);
            end
            repeat (gap) begin
               @(negedge clock);
               req_ch.valid = 1'b0;
            end
         end
         burst_left--;
         // Start the long receiver hold-off; keep offering requests meanwhile.
         if (with_hold && k == 8) hold_req = 1'b1;
         send_request(stream[k].data, stream[k].first);
      end
      stream.delete();
   endtask

   initial begin : stimulus
      cfg_type     c;
      int unsigned p, phase_no;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_INDEX_BITS;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.in_byte = 8'h00;
      req_ch.block_start = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Decode against the reset state, before any block start.
      send_request(8'hFE, 1'b0);
      // Token at the top of the window that wraps to entry zero, longest copy.
      send_request(8'hFF, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h5A, 1'b0);
      send_request(8'hA5, 1'b0);
      send_request(8'h01, 1'b0);
      send_request(8'h80, 1'b0);
      send_request(8'h7F, 1'b0);
      send_request(8'h00, 1'b0);
      // Copy from one byte back: every read hits the byte written just before it.
      p = (decoder.wr_pos - 1) & (WIN_DEPTH - 1);
      send_request(8'(p), 1'b0);
      send_request({4'(p >> 8), 4'h3}, 1'b0);
      // Copy from two bytes back with a zero coded length.
      p = (decoder.wr_pos - 2) & (WIN_DEPTH - 1);
      send_request(8'(p), 1'b0);
      send_request({4'(p >> 8), 4'h0}, 1'b0);
      // Open a token, then cut it off with a block start.
      send_request(8'h33, 1'b0);
      send_request(8'hFF, 1'b1);
      send_request(8'h11, 1'b0);
      send_request(8'hEE, 1'b0);
      quiesce();

      // Smallest window, interleaved fill, and an output limit hit inside a copy.
      c = CFG_RESET;
      c.index_bits = 4'd8;
      c.length_bits = 3'd2;
      c.min_match = 4'd15;
      c.start_back = 4'd15;
      c.init_mode = INIT_INTERLEAVE;
      c.fill_byte = 8'hA5;
      c.max_output = CNT_W'(20);
      configure(c);
      send_request(8'h00, 1'b1);
      send_request(8'h06, 1'b0);
      send_request(8'h03, 1'b0);
      send_request(8'h0E, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'h01, 1'b1);
      send_request(8'h42, 1'b0);
      quiesce();

      // Random phases: first the register extremes (out of range too), then random settings.
      phase_no = 0;
      while (sent_count < 400) begin
         case (phase_no)
            0: begin
               c.index_bits = 4'd0;
               c.length_bits = 3'd0;
               c.min_match = 4'd0;
               c.start_back = 4'd0;
               c.init_mode = 2'd3;
               c.fill_byte = 8'hFF;
               c.max_output = '1;
            end
            1: begin
               c.index_bits = 4'd15;
               c.length_bits = 3'd7;
               c.min_match = 4'd15;
               c.start_back = 4'd15;
               c.init_mode = INIT_ASCENDING;
               c.fill_byte = 8'h00;
               c.max_output = '0;
            end
            default: begin
               c.index_bits = 4'($urandom);
               c.length_bits = 3'($urandom);
               c.min_match = 4'($urandom);
               c.start_back = 4'($urandom);
               c.init_mode = 2'($urandom);
               c.fill_byte = 8'($urandom);
               case ($urandom_range(0, 3))
                  0:       c.max_output = CNT_W'($urandom_range(0, 80));
                  1:       c.max_output = CNT_W'($urandom);
                  default: c.max_output = CNT_W'(1 << 20);
               endcase
            end
         endcase
         configure(c);
         build_phase(phase_no);
         play_stream(phase_no == 0);
         quiesce();
         phase_no++;
      end

      if (decoder.mismatches == 0 && decoder.pending_bytes.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("Verification failed");
      $finish;
   end

endmodule

/* sim.f */
sv/lzss_pkg.sv
sv/lzss_if.sv
sv/lzss_window.sv
sv/lzss_decoder.sv
sv/lzss_decompressor.sv
test/lzss_tb_pkg.sv
test/tb_lzss_decompressor.sv
